// ===== hdl/plcm_pkg.sv =====
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared constants, types and palette tables of the colormap block.
// ----------------------------------------------------------------------------
package plcm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CHAN_W           = 8;
    localparam int MODE_W           = 4;
    localparam int KNOT_IDX_W       = 3;
    localparam int MAX_KNOTS        = 5;

    localparam logic [MODE_W-1:0] PAL_NONE = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PALETTE_MODE = 2'd0,
        REG_INVERT       = 2'd1,
        REG_WINDOW_LOW   = 2'd2,
        REG_WINDOW_HIGH  = 2'd3
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        PAL_GRAY      = 4'd0,
        PAL_RED_BLUE  = 4'd1,
        PAL_BRW       = 4'd2,
        PAL_BBW       = 4'd3,
        PAL_BYW       = 4'd4,
        PAL_BLUE_WH   = 4'd5,
        PAL_BLACKBODY = 4'd6,
        PAL_SPECTRUM  = 4'd7
    } palette_t;

    typedef struct packed {
        logic [2:0]        quarter;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } knot_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic knot_t mk(input logic [2:0] q, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
        knot_t k;
        k.quarter = q;
        k.r = r;
        k.g = g;
        k.b = b;
        return k;
    endfunction

    // number of knots, zero for an empty palette
    function automatic logic [KNOT_IDX_W-1:0] palette_count(input logic [MODE_W-1:0] mode);
        logic [KNOT_IDX_W-1:0] c;
        c = '0;
        if (mode < PAL_NONE)
        begin
            unique case (palette_t'(mode[2:0]))
                PAL_GRAY, PAL_RED_BLUE: c = 3'd2;
                PAL_BRW, PAL_BBW, PAL_BYW, PAL_BLUE_WH: c = 3'd3;
                PAL_BLACKBODY: c = 3'd4;
                PAL_SPECTRUM:  c = 3'd5;
                default:       c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic knot_t palette_knot(input logic [MODE_W-1:0] mode,
                                           input logic [KNOT_IDX_W-1:0] idx);
        knot_t k;
        k = '0;
        unique case (palette_t'(mode[2:0]))
            PAL_GRAY:
                k = (idx == 3'd0) ? mk(3'd0, 8'd0, 8'd0, 8'd0) : mk(3'd4, 8'd255, 8'd255, 8'd255);
            PAL_RED_BLUE:
                k = (idx == 3'd0) ? mk(3'd0, 8'd255, 8'd0, 8'd0) : mk(3'd4, 8'd0, 8'd0, 8'd255);
            PAL_BRW:
                k = (idx == 3'd0) ? mk(3'd0, 8'd0, 8'd0, 8'd0) :
                    (idx == 3'd1) ? mk(3'd2, 8'd255, 8'd0, 8'd0) :
                                    mk(3'd4, 8'd255, 8'd255, 8'd255);
            PAL_BBW:
                k = (idx == 3'd0) ? mk(3'd0, 8'd0, 8'd0, 8'd0) :
                    (idx == 3'd1) ? mk(3'd2, 8'd0, 8'd0, 8'd255) :
                                    mk(3'd4, 8'd255, 8'd255, 8'd255);
            PAL_BYW:
                k = (idx == 3'd0) ? mk(3'd0, 8'd0, 8'd0, 8'd0) :
                    (idx == 3'd1) ? mk(3'd2, 8'd255, 8'd255, 8'd0) :
                                    mk(3'd4, 8'd255, 8'd255, 8'd255);
            PAL_BLUE_WH:
                k = (idx == 3'd0) ? mk(3'd0, 8'd0, 8'd0, 8'd255) :
                    (idx == 3'd1) ? mk(3'd2, 8'd0, 8'd255, 8'd255) :
                                    mk(3'd4, 8'd255, 8'd255, 8'd255);
            PAL_BLACKBODY:
                k = (idx == 3'd0) ? mk(3'd0, 8'd128, 8'd0, 8'd0) :
                    (idx == 3'd1) ? mk(3'd1, 8'd255, 8'd0, 8'd0) :
                    (idx == 3'd2) ? mk(3'd2, 8'd255, 8'd255, 8'd0) :
                                    mk(3'd4, 8'd255, 8'd255, 8'd255);
            PAL_SPECTRUM:
                k = (idx == 3'd0) ? mk(3'd0, 8'd0, 8'd0, 8'd255) :
                    (idx == 3'd1) ? mk(3'd1, 8'd0, 8'd255, 8'd255) :
                    (idx == 3'd2) ? mk(3'd2, 8'd0, 8'd255, 8'd0) :
                    (idx == 3'd3) ? mk(3'd3, 8'd255, 8'd255, 8'd0) :
                                    mk(3'd4, 8'd255, 8'd0, 8'd0);
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/plcm_front.sv =====
// ----------------------------------------------------------------------------
// plcm_front
// Input register: takes a sample and forms the window offsets.
// ----------------------------------------------------------------------------
module plcm_front #(
    parameter int SAMPLE_WIDTH = plcm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [SAMPLE_WIDTH-1:0]   sample,
    input  logic [SAMPLE_WIDTH-1:0]   window_low,
    input  logic [SAMPLE_WIDTH-1:0]   window_high,
    output logic                      push,
    input  logic                      queue_full,
    output logic [2*SAMPLE_WIDTH+1:0] word
);

    logic                    valid_reg;
    logic [SAMPLE_WIDTH:0]   num_reg;
    logic [SAMPLE_WIDTH:0]   den_reg;
    logic [SAMPLE_WIDTH:0]   num_next;
    logic [SAMPLE_WIDTH:0]   den_next;

    assign push     = valid_reg && !queue_full;
    assign in_ready = !valid_reg || !queue_full;
    assign word     = {den_reg, num_reg};

    always_comb
    begin
        num_next = {sample[SAMPLE_WIDTH-1], sample}
                 - {window_low[SAMPLE_WIDTH-1], window_low};
        den_next = {window_high[SAMPLE_WIDTH-1], window_high}
                 - {window_low[SAMPLE_WIDTH-1], window_low};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

endmodule

// ===== hdl/plcm_queue.sv =====
// ----------------------------------------------------------------------------
// plcm_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module plcm_queue #(
    parameter int WIDTH = 66,
    parameter int DEPTH = plcm_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_word,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_word,
    output plcm_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign pop_word     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

// ===== hdl/plcm_back.sv =====
// ----------------------------------------------------------------------------
// plcm_back
// Divider pipeline for the position, then palette segment and blend.
// ----------------------------------------------------------------------------
module plcm_back #(
    parameter int SAMPLE_WIDTH       = plcm_pkg::SAMPLE_WIDTH_DEF,
    parameter int POSITION_FRAC_BITS = plcm_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            queue_empty,
    input  logic [2*SAMPLE_WIDTH+1:0]       word,
    output logic                            pop,
    input  logic [plcm_pkg::MODE_W-1:0]     palette_mode,
    input  logic                            invert,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [3*plcm_pkg::CHAN_W-1:0]   out_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int F     = POSITION_FRAC_BITS;
    localparam int LAST  = F + 2;
    localparam int PW    = plcm_pkg::CHAN_W + F + 1;
    localparam int CW    = plcm_pkg::CHAN_W;
    localparam logic [F:0] POS_ONE = (F+1)'(1) << F;

    logic              adv;
    logic [LAST:0]     vld_reg;

    // divider stages 0..F
    logic [SW:0]       rem_reg  [F+1];
    logic [SW:0]       dvs_reg  [F+1];
    logic [F-1:0]      quo_reg  [F+1];
    logic              full_reg [F+1];

    logic signed [SW:0] num;
    logic signed [SW:0] den;
    logic [SW:0]        n_abs;
    logic [SW:0]        d_abs;

    // blend stage
    logic [PW-1:0]     p0_reg [3];
    logic [PW-1:0]     p1_reg [3];
    logic [1:0]        sh_reg;
    logic [CW-1:0]     col_reg [3];

    logic [F:0]        x;
    logic [F:0]        x0;
    logic [F:0]        x1;
    logic [1:0]        sh;
    plcm_pkg::knot_t   k0;
    plcm_pkg::knot_t   k1;
    logic [PW-1:0]     p0_next [3];
    logic [PW-1:0]     p1_next [3];

    assign adv       = !vld_reg[LAST] || out_ready;
    assign pop       = adv && !queue_empty;
    assign out_valid = vld_reg[LAST];
    assign out_data  = {col_reg[2], col_reg[1], col_reg[0]};

    assign num   = word[SW:0];
    assign den   = word[2*SW+1:SW+1];
    assign n_abs = num[SW] ? -num : num;
    assign d_abs = den[SW] ? -den : den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], !queue_empty};
        end
    end

    // classify: trivial zero, saturated one, or a true fraction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_reg[0] <= '0;
            if (den == '0 || num == '0 || (num[SW] != den[SW]))
            begin
                rem_reg[0]  <= '0;
                dvs_reg[0]  <= (SW+1)'(1);
                full_reg[0] <= 1'b0;
            end
            else
            begin
                rem_reg[0]  <= n_abs;
                dvs_reg[0]  <= d_abs;
                full_reg[0] <= (n_abs >= d_abs);
            end
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= F; i++)
    begin : g_div
        logic [SW+1:0] r2;
        assign r2 = {rem_reg[i-1], 1'b0};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dvs_reg[i]  <= dvs_reg[i-1];
                full_reg[i] <= full_reg[i-1];
                if (!full_reg[i-1] && r2 >= {1'b0, dvs_reg[i-1]})
                begin
                    rem_reg[i] <= (SW+1)'(r2 - {1'b0, dvs_reg[i-1]});
                    quo_reg[i] <= {quo_reg[i-1][F-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= r2[SW:0];
                    quo_reg[i] <= {quo_reg[i-1][F-2:0], 1'b0};
                end
            end
        end
    end

    function automatic logic [2:0] palette_knot_q(input logic [2:0] idx);
        plcm_pkg::knot_t k;
        k = plcm_pkg::palette_knot(palette_mode, idx);
        return k.quarter;
    endfunction

    // segment search over the knots of the selected palette
    always_comb
    begin
        logic [F:0]                     xp;
        logic [plcm_pkg::KNOT_IDX_W-1:0] cnt;
        logic [plcm_pkg::KNOT_IDX_W-1:0] seg;
        logic                           done;
        logic [F:0]                     kp;
        logic [2:0]                     span;
        xp   = full_reg[F] ? POS_ONE : {1'b0, quo_reg[F]};
        x    = invert ? POS_ONE - xp : xp;
        cnt  = plcm_pkg::palette_count(palette_mode);
        seg  = '0;
        done = 1'b0;
        kp   = '0;
        for (int i = 1; i < plcm_pkg::MAX_KNOTS; i++)
        begin
            if (!done && 3'(i) < cnt)
            begin
                seg = 3'(i - 1);
                kp  = (F+1)'(palette_knot_q(3'(i))) << (F - 2);
                if (kp >= x)
                begin
                    done = 1'b1;
                end
            end
        end
        k0   = plcm_pkg::palette_knot(palette_mode, seg);
        k1   = plcm_pkg::palette_knot(palette_mode, seg + 1'b1);
        if (cnt == '0)
        begin
            k0 = '0;
            k1 = '0;
        end
        x0   = (F+1)'(k0.quarter) << (F - 2);
        x1   = (F+1)'(k1.quarter) << (F - 2);
        span = k1.quarter - k0.quarter;
        sh   = (span == 3'd4) ? 2'd2 : (span == 3'd2) ? 2'd1 : 2'd0;
        p0_next[0] = PW'(k0.r) * PW'(x1 - x);
        p1_next[0] = PW'(k1.r) * PW'(x - x0);
        p0_next[1] = PW'(k0.g) * PW'(x1 - x);
        p1_next[1] = PW'(k1.g) * PW'(x - x0);
        p0_next[2] = PW'(k0.b) * PW'(x1 - x);
        p1_next[2] = PW'(k1.b) * PW'(x - x0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sh_reg <= sh;
            for (int c = 0; c < 3; c++)
            begin
                p0_reg[c] <= p0_next[c];
                p1_reg[c] <= p1_next[c];
            end
        end
    end

    // span is a power of two quarters, so the divide is a shift
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                col_reg[c] <= CW'(({1'b0, p0_reg[c]} + {1'b0, p1_reg[c]})
                                  >> ((F - 2) + int'(sh_reg)));
            end
        end
    end

endmodule

// ===== hdl/piecewise_linear_colormap.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_colormap
// False-color map of a signed sample stream to 8-bit RGB words.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while s_tready is high and returns one RGB
// word per sample, in order. A sample passes through the input register, the
// queue, the classify stage, one restoring-divider stage per position bit,
// the multiply stage and the output register. The four-word queue lets the
// input side keep accepting while the output is stalled. Configuration
// writes are taken at any time and must be made while no sample is in
// flight.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap #(
    parameter int SAMPLE_WIDTH       = plcm_pkg::SAMPLE_WIDTH_DEF,
    parameter int POSITION_FRAC_BITS = plcm_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,   // sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [3*plcm_pkg::CHAN_W-1:0]      m_tdata,   // red, green, blue
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]            cfg_data
);

    localparam int QW = 2 * SAMPLE_WIDTH + 2;

    logic [plcm_pkg::MODE_W-1:0] palette_mode_reg;
    logic                        invert_reg;
    logic [SAMPLE_WIDTH-1:0]     window_low_reg;
    logic [SAMPLE_WIDTH-1:0]     window_high_reg;

    logic                        push;
    logic                        pop;
    logic [QW-1:0]               push_word;
    logic [QW-1:0]               pop_word;
    plcm_pkg::queue_status_t     qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_mode_reg <= plcm_pkg::PAL_NONE;
            invert_reg       <= 1'b0;
            window_low_reg   <= '0;
            window_high_reg  <= SAMPLE_WIDTH'(255);
        end
        else if (cfg_valid)
        begin
            unique case (plcm_pkg::cfg_reg_t'(cfg_index))
                plcm_pkg::REG_PALETTE_MODE: palette_mode_reg <= cfg_data[plcm_pkg::MODE_W-1:0];
                plcm_pkg::REG_INVERT:       invert_reg       <= cfg_data[0];
                plcm_pkg::REG_WINDOW_LOW:   window_low_reg   <= cfg_data;
                plcm_pkg::REG_WINDOW_HIGH:  window_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    plcm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata[SAMPLE_WIDTH-1:0]),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .push        (push),
        .queue_full  (qstat.full),
        .word        (push_word)
    );

    plcm_queue #(
        .WIDTH (QW),
        .DEPTH (plcm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .status    (qstat)
    );

    plcm_back #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (qstat.empty),
        .word         (pop_word),
        .pop          (pop),
        .palette_mode (palette_mode_reg),
        .invert       (invert_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata)
    );

    // queue can never be full and empty at once
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty together");

    // a word pushed into the queue is there on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !qstat.empty)
        else $error("pushed word lost");

    // input stalls only when the front register holds a word it cannot pass on
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> qstat.full)
        else $error("input stalled with room in the queue");

endmodule
